// ===== sv/capm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capm_pkg
// shared types and constants of the capture pair frequency meter
// ----------------------------------------------------------------------------
package capm_pkg;

   localparam int CAPTURE_W = 16;
   localparam int TOP_W     = 16;
   localparam int CLOCK_W   = 24;
   localparam int PERIOD_W  = 17;
   localparam int FREQ_W    = 16;
   localparam int DIV_STEPS = CLOCK_W;
   localparam int STEP_W    = 5;
   localparam int ADDR_W    = 3;

   localparam logic [TOP_W-1:0]   TOP_RESET   = 16'd1388;
   localparam logic [CLOCK_W-1:0] CLOCK_RESET = 24'(16000000 / 64);
   localparam logic [FREQ_W-1:0]  FREQ_MAX    = 16'hFFFF;

   // register index, taken from the word address bit
   localparam logic REG_COUNTER_TOP    = 1'b0;
   localparam logic REG_COUNT_CLOCK_HZ = 1'b1;

   typedef struct packed {
      logic [TOP_W-1:0]   counter_top;
      logic [CLOCK_W-1:0] count_clock_hz;
   } cfg_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_LOAD
   } back_state_type;

endpackage

// ===== sv/capm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capm_front
// pairs up capture beats and works out the period of each pair
// ----------------------------------------------------------------------------
module capm_front import capm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CAPTURE_W-1:0] req_capture_value,
   output logic                 push_valid,
   input  logic                 push_ready,
   output logic [PERIOD_W-1:0]  push_period
);

   logic [TOP_W-1:0] first_stamp_ff, first_stamp_in;
   logic             have_first_ff, have_first_in;
   logic [TOP_W-1:0] stamp;
   logic             accept;

   assign stamp = (req_capture_value > cfg.counter_top) ? cfg.counter_top
                                                         : req_capture_value;

   assign req_ready  = !have_first_ff || push_ready;
   assign push_valid = req_valid && have_first_ff;
   assign accept     = req_valid && req_ready;

   always_comb begin
      if (first_stamp_ff < stamp) begin
         push_period = PERIOD_W'(stamp) - PERIOD_W'(first_stamp_ff);
      end else begin
         // count went across the wrap
         push_period = PERIOD_W'(cfg.counter_top) + PERIOD_W'(1)
                       - PERIOD_W'(first_stamp_ff) + PERIOD_W'(stamp);
      end
   end

   always_comb begin
      first_stamp_in = first_stamp_ff;
      have_first_in  = have_first_ff;
      if (accept) begin
         if (!have_first_ff) begin
            first_stamp_in = stamp;
            have_first_in  = 1'b1;
         end else begin
            have_first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_stamp_ff <= '0;
         have_first_ff  <= 1'b0;
      end else begin
         first_stamp_ff <= first_stamp_in;
         have_first_ff  <= have_first_in;
      end
   end

endmodule

// ===== sv/capm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capm_queue
// short fifo of periods between the pairing front and the divider
// ----------------------------------------------------------------------------
module capm_queue import capm_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [PERIOD_W-1:0] in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [PERIOD_W-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [PERIOD_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push, pop;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign out_data  = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (count_ff == FULL_CNT && !pop) |-> !push)
      else $error("push into full queue");

endmodule

// ===== sv/capm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capm_back
// restoring divider, count clock over period, with saturated result register
// ----------------------------------------------------------------------------
module capm_back import capm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  logic [PERIOD_W-1:0] pop_period,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PERIOD_W-1:0] rsp_period_ticks,
   output logic [FREQ_W-1:0]   rsp_frequency_hz
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   back_state_type      state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PERIOD_W-1:0] divisor_ff, divisor_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [CLOCK_W-1:0]  quo_ff, quo_in;
   logic [PERIOD_W:0]   rem_shift;
   logic [PERIOD_W+1:0] diff;
   logic                start, load_out;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0] rsp_period_ff;
   logic [FREQ_W-1:0]   rsp_freq_ff, freq_sat;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) state_in = S_DIV;
         end
         S_DIV: begin
            if (step_ff == LAST_STEP) state_in = S_LOAD;
         end
         S_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      start    = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         S_IDLE:  start    = pop_valid;
         S_DIV:   ;
         S_LOAD:  load_out = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign pop_ready = start;

   // one quotient bit per cycle, dividend shifts out of the quotient register
   assign rem_shift = {rem_ff, quo_ff[CLOCK_W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, divisor_ff};

   always_comb begin
      step_in    = step_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (start) begin
         step_in    = '0;
         divisor_in = pop_period;
         rem_in     = '0;
         quo_in     = cfg.count_clock_hz;
      end else if (state_ff == S_DIV) begin
         step_in = step_ff + STEP_W'(1);
         if (diff[PERIOD_W+1]) begin
            rem_in = rem_shift[PERIOD_W-1:0];
         end else begin
            rem_in = diff[PERIOD_W-1:0];
         end
         quo_in = {quo_ff[CLOCK_W-2:0], ~diff[PERIOD_W+1]};
      end
   end

   assign freq_sat = (|quo_ff[CLOCK_W-1:FREQ_W]) ? FREQ_MAX : quo_ff[FREQ_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      if (load_out) begin
         rsp_period_ff <= divisor_ff;
         rsp_freq_ff   <= freq_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_period_ticks = rsp_period_ff;
   assign rsp_frequency_hz = rsp_freq_ff;

   a_start_div: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == S_DIV && step_ff == '0))
      else $error("divider did not start cleanly");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (divisor_ff != '0))
      else $error("zero period reached divider");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (step_ff <= LAST_STEP))
      else $error("divider step count overrun");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result load lost");

endmodule

// ===== sv/capture_pair_frequency_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_pair_frequency_meter
// pairs input-capture timestamps and reports period and frequency
// ----------------------------------------------------------------------------
//  channel | ports                                   | beat
//  --------+-----------------------------------------+---------------------------
//  req     | req_valid/req_ready, req_capture_value  | one timer capture
//  rsp     | rsp_valid/rsp_ready, rsp_period_ticks,  | one result per capture pair
//          | rsp_frequency_hz                        |
//  csr     | psel/penable/pwrite/paddr/pwdata/prdata | counter_top @0, count_clock_hz @4
//
//  flow: the first beat of a pair is always taken; the second beat of a pair
//  queues its period, and the divider pops it, works out the quotient bit by
//  bit and loads the result register before it takes the next period
//  reset: synchronous, clears pairing state, queue, divider state and rsp_valid
//  stalls: a full period queue holds off only the second beat of a pair;
//  a stalled rsp beat holds the divider in its load cycle
// ----------------------------------------------------------------------------
module capture_pair_frequency_meter import capm_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   // capture input
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CAPTURE_W-1:0] req_capture_value,
   // result output
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PERIOD_W-1:0]  rsp_period_ticks,
   output logic [FREQ_W-1:0]    rsp_frequency_hz,
   // register port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   cfg_type             cfg_ff, cfg_in;
   logic                csr_write;
   logic                push_valid, push_ready;
   logic [PERIOD_W-1:0] push_period;
   logic                pop_valid, pop_ready;
   logic [PERIOD_W-1:0] pop_period;

   // register file, always ready, word address bit picks the register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_COUNTER_TOP:    cfg_in.counter_top    = pwdata[TOP_W-1:0];
            REG_COUNT_CLOCK_HZ: cfg_in.count_clock_hz = pwdata[CLOCK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_COUNTER_TOP:    prdata = 32'(cfg_ff.counter_top);
         REG_COUNT_CLOCK_HZ: prdata = 32'(cfg_ff.count_clock_hz);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counter_top    <= TOP_RESET;
         cfg_ff.count_clock_hz <= CLOCK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: clamp, pair up, period
   capm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_capture_value (req_capture_value),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_period       (push_period)
   );

   // period queue decouples pairing from division
   capm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_period),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_period)
   );

   // back: iterative divide and result register
   capm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_period       (pop_period),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_period_ticks (rsp_period_ticks),
      .rsp_frequency_hz (rsp_frequency_hz)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the capture pair frequency meter: captures are fed
// in pairs under random valid/ready gaps, each result beat is checked against
// a period and frequency prediction, and the timer registers are rewritten
// between phases, extremes included
// ----------------------------------------------------------------------------
module tb import capm_pkg::*;;

   localparam int LIMIT_CYCLES  = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 124;   // even, so a phase never ends mid-pair
   localparam int IDLE_PCT      = 28;

   typedef struct {
      logic [PERIOD_W-1:0] period_ticks;
      logic [FREQ_W-1:0]   frequency_hz;
   } pair_result_type;

   // predicts period and frequency per capture pair and holds the results due
   class pair_meter_board;
      logic [TOP_W-1:0]     timer_top;
      logic [CLOCK_W-1:0]   tick_hz;
      logic [CAPTURE_W-1:0] first_stamp;
      logic                 have_first;
      pair_result_type      awaiting[$];
      int                   errors;

      function new();
         timer_top   = TOP_RESET;
         tick_hz     = CLOCK_RESET;
         first_stamp = '0;
         have_first  = 1'b0;
         errors      = 0;
      endfunction

      function void note_capture(logic [CAPTURE_W-1:0] raw);
         logic [CAPTURE_W-1:0] stamp;
         logic [PERIOD_W-1:0]  period;
         logic [31:0]          quot;
         pair_result_type      res;
         stamp = (raw > timer_top) ? timer_top : raw;
         if (!have_first) begin
            first_stamp = stamp;
            have_first  = 1'b1;
            return;
         end
         if (first_stamp < stamp) begin
            period = PERIOD_W'(stamp) - PERIOD_W'(first_stamp);
         end else begin
            period = PERIOD_W'(timer_top) + 17'd1 - PERIOD_W'(first_stamp)
                     + PERIOD_W'(stamp);
         end
         quot = 32'(tick_hz) / 32'(period);
         res.period_ticks = period;
         res.frequency_hz = (quot > 32'(FREQ_MAX)) ? FREQ_MAX : quot[FREQ_W-1:0];
         have_first = 1'b0;
         awaiting.push_back(res);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_result(logic [PERIOD_W-1:0] period, logic [FREQ_W-1:0] freq);
         pair_result_type want;
         if (awaiting.size() == 0) begin
            report($sformatf("unexpected beat period %0d freq %0d", period, freq));
            return;
         end
         want = awaiting.pop_front();
         if (period !== want.period_ticks)
            report($sformatf("period_ticks %0d, want %0d", period, want.period_ticks));
         if (freq !== want.frequency_hz)
            report($sformatf("frequency_hz %0d, want %0d", freq, want.frequency_hz));
      endtask
   endclass

   // every input known from time zero
   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic [CAPTURE_W-1:0] req_capture_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   logic [PERIOD_W-1:0]  rsp_period_ticks;
   logic [FREQ_W-1:0]    rsp_frequency_hz;
   logic                 psel              = 1'b0;
   logic                 penable           = 1'b0;
   logic                 pwrite            = 1'b0;
   logic [ADDR_W-1:0]    paddr             = '0;
   logic [31:0]          pwdata            = '0;
   logic [31:0]          prdata;
   logic                 pready;

   logic                 calm              = 1'b0;  // no idling on either side
   int                   cycles            = 0;
   pair_meter_board      board             = new;

   capture_pair_frequency_meter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_capture_value (req_capture_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_period_ticks  (rsp_period_ticks),
      .rsp_frequency_hz  (rsp_frequency_hz),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #2 clock = ~clock;

   // watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random back-pressure except in the calm stretch
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // monitors sample pre-edge values, so ordering against the dut is moot
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_capture(req_capture_value);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_period_ticks, rsp_frequency_hz);
   end

   // one capture beat; valid stays up from the accepting edge into the next beat
   task send_capture(input logic [CAPTURE_W-1:0] value);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_capture_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task send_pair(input logic [CAPTURE_W-1:0] start, input logic [CAPTURE_W-1:0] stop);
      send_capture(start);
      send_capture(stop);
   endtask

   // setup then access cycle; the register takes the value at the access edge
   task write_reg(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // psel drops, leaving the bus idle before the next transfer
      @(posedge clock);
      if (idx == REG_COUNTER_TOP)
         board.timer_top = value[TOP_W-1:0];
      else
         board.tick_hz = value[CLOCK_W-1:0];
   endtask

   // the extra edge lets the monitor log the last capture before the check
   task settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.awaiting.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task set_timer(input logic [TOP_W-1:0] top, input logic [CLOCK_W-1:0] hz);
      write_reg(REG_COUNTER_TOP, 32'(top));
      write_reg(REG_COUNT_CLOCK_HZ, 32'(hz));
   endtask

   // random captures under one timer setting, biased toward edges and repeats
   task run_phase(input logic [TOP_W-1:0] top, input logic [CLOCK_W-1:0] hz);
      logic [CAPTURE_W-1:0] value;
      logic [CAPTURE_W-1:0] last;
      last = '0;
      set_timer(top, hz);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         case ($urandom_range(9))
            0: value = CAPTURE_W'($urandom_range(65535));   // often above top
            1: value = top;
            2: value = '0;
            3: value = last;                                // full wrap
            4: value = (last < top) ? last + 1'b1 : '0;     // shortest period
            default: value = CAPTURE_W'($urandom_range(32'(top)));
         endcase
         send_capture(value);
         last = value;
      end
      settle();
   endtask

   initial begin
      logic [TOP_W-1:0]   top;
      logic [CLOCK_W-1:0] hz;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: top 1388, 250 khz
      send_pair(16'd0, 16'd1388);       // longest plain period
      send_pair(16'd1388, 16'd0);       // across the wrap, one tick
      send_pair(16'd100, 16'd100);      // equal captures, full wrap
      send_pair(16'hFFFF, 16'd5);       // start above top clamps
      send_pair(16'd5, 16'hFFFF);       // stop above top clamps
      send_pair(16'd10, 16'd11);        // frequency saturates
      send_pair(16'h8000, 16'h7FFF);    // both clamp, equal after clamp
      settle();

      // widest timer and fastest clock
      set_timer(16'hFFFF, 24'hFFFFFF);
      send_pair(16'd0, 16'hFFFF);
      send_pair(16'hFFFF, 16'hFFFF);    // period of 65536
      send_pair(16'd0, 16'd0);
      send_pair(16'hFFFF, 16'd0);
      settle();

      // degenerate top and a stopped clock
      set_timer(16'd0, 24'd0);
      send_pair(16'd0, 16'd0);
      send_pair(16'hFFFF, 16'd123);
      settle();

      // slowest legal setting
      set_timer(16'd1, 24'd1);
      send_pair(16'd0, 16'd1);
      send_pair(16'd1, 16'd0);
      send_pair(16'd1, 16'd1);
      settle();

      for (int phase = 0; phase < 10; phase++) begin
         calm = (phase == 3);
         case (phase)
            0: begin top = 16'hFFFF; hz = 24'hFFFFFF; end
            1: begin top = 16'd1;    hz = 24'd1;      end
            3: begin
               top = TOP_W'($urandom_range(64, 2));
               hz  = CLOCK_W'($urandom_range(4096, 1));
            end
            4: begin top = 16'hFFFF; hz = CLOCK_W'($urandom_range(300000, 1)); end
            5: begin top = TOP_W'($urandom_range(65535, 1)); hz = 24'hFFFFFF; end
            6: begin top = TOP_RESET; hz = CLOCK_RESET; end
            8: begin
               top = TOP_W'($urandom_range(15, 1));
               hz  = CLOCK_W'($urandom_range(16777215, 1));
            end
            default: begin
               top = TOP_W'($urandom_range(65535, 1));
               hz  = CLOCK_W'($urandom_range(16777215, 1));
            end
         endcase
         run_phase(top, hz);
      end
      calm = 1'b0;

      if (board.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
